### design/rsc_pkg.sv
// Shared types, codes and conversion functions for row_scatter_convert.
// No dependencies.
`default_nettype none
package rsc_pkg;
	localparam int unsigned DIM_W    = 17;
	localparam int unsigned STRIDE_W = 32;
	localparam int unsigned OFF_W    = 48;
	localparam int unsigned DROW_W   = 24;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned BYTES_W  = 3;

	typedef enum logic [1:0] {
		FMT_FP32 = 2'd0,
		FMT_FP16 = 2'd1,
		FMT_BF16 = 2'd2
	} fmt_t;

	typedef enum logic [2:0] {
		REG_ROW_LENGTH   = 3'd0,
		REG_ROWS_PLANE   = 3'd1,
		REG_PLANES_BATCH = 3'd2,
		REG_ROW_STRIDE   = 3'd3,
		REG_PLANE_STRIDE = 3'd4,
		REG_BATCH_STRIDE = 3'd5,
		REG_OUT_FORMAT   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] row_length;
		logic [DIM_W-1:0] rows_per_plane;
		logic [DIM_W-1:0] planes_per_batch;
		logic [STRIDE_W-1:0] row_stride;
		logic [STRIDE_W-1:0] plane_stride;
		logic [STRIDE_W-1:0] batch_stride;
		logic [1:0] out_format;
	} cfg_t;

	function automatic logic [15:0] to_fp16(input logic [31:0] x);
		logic [15:0] sign;
		logic [7:0]  ex;
		logic [22:0] man;
		logic [23:0] m;
		logic [4:0]  shift;
		logic [23:0] h;
		logic [23:0] rem;
		logic [23:0] half;
		logic [15:0] r;
		sign = {x[31], 15'd0};
		ex   = x[30:23];
		man  = x[22:0];
		m    = {1'b1, man};
		shift = 5'd0;
		h = 24'd0;
		rem = 24'd0;
		half = 24'd0;
		if (ex == 8'hFF) begin
			if (man != 23'd0) r = sign | 16'h7E00 | {6'd0, man[22:13]};
			else r = sign | 16'h7C00;
		end else if (ex >= 8'd143) begin
			r = sign | 16'h7C00;
		end else if (ex <= 8'd112) begin
			if (ex < 8'd102) begin
				r = sign;
			end else begin
				shift = 5'(8'd126 - ex);
				h     = m >> shift;
				half  = 24'd1 << (shift - 5'd1);
				rem   = m & ((24'd1 << shift) - 24'd1);
				if (rem > half || (rem == half && h[0])) h = h + 24'd1;
				r = sign | h[15:0];
			end
		end else begin
			h   = {9'd0, 5'(ex - 8'd112), man[22:13]};
			rem = {11'd0, man[12:0]};
			if (rem > 24'h1000 || (rem == 24'h1000 && h[0])) h = h + 24'd1;
			r = sign | h[15:0];
		end
		return r;
	endfunction

	function automatic logic [15:0] to_bf16(input logic [31:0] x);
		logic [31:0] s;
		logic [15:0] r;
		s = x + 32'h7FFF + {31'd0, x[16]};
		if (x[30:23] == 8'hFF && x[22:0] != 23'd0) r = x[31:16] | 16'h0040;
		else r = s[31:16];
		return r;
	endfunction
endpackage
`default_nettype wire

### design/rsc_position.sv
// Column, row, plane and batch position counters with wrap and restart.
// Depends on rsc_pkg.
`default_nettype none
module rsc_position #(
	parameter int unsigned PW = 16,
	parameter int unsigned MAX_DIM = 65536
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire logic first,
	input  wire rsc_pkg::cfg_t cfg,
	output logic [PW-1:0] col,
	output logic [PW-1:0] plane,
	output logic [PW-1:0] batch
);
	localparam int unsigned CW = (PW + 1 > rsc_pkg::DIM_W) ? PW + 1 : rsc_pkg::DIM_W;
	localparam logic [CW-1:0] MAXD = CW'(MAX_DIM);

	logic [PW-1:0] col_q, row_q, plane_q, batch_q;
	logic [PW-1:0] row;
	logic [PW-1:0] col_n, row_n, plane_n, batch_n;
	logic wc, wr, wp, wb;

	function automatic logic [CW-1:0] clampd(input logic [rsc_pkg::DIM_W-1:0] d);
		logic [CW-1:0] e;
		e = CW'(d);
		if (e == '0) e = CW'(1);
		else if (e > MAXD) e = MAXD;
		return e;
	endfunction

	function automatic logic [PW:0] step(input logic [PW-1:0] p, input logic [CW-1:0] d);
		logic [CW-1:0] nx;
		nx = CW'(p) + CW'(1);
		if (nx >= d) return {1'b1, {PW{1'b0}}};
		return {1'b0, nx[PW-1:0]};
	endfunction

	assign col   = first ? '0 : col_q;
	assign row   = first ? '0 : row_q;
	assign plane = first ? '0 : plane_q;
	assign batch = first ? '0 : batch_q;

	always_comb begin
		{wc, col_n} = step(col, clampd(cfg.row_length));
		{wr, row_n} = step(row, clampd(cfg.rows_per_plane));
		{wp, plane_n} = step(plane, clampd(cfg.planes_per_batch));
		{wb, batch_n} = step(batch, MAXD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			plane_q <= '0;
			batch_q <= '0;
		end else if (adv) begin
			col_q <= col_n;
			row_q <= wc ? row_n : row;
			plane_q <= (wc && wr) ? plane_n : plane;
			batch_q <= (wc && wr && wp) ? batch_n : batch;
		end
	end

	logic unused_wb;
	assign unused_wb = wb;
endmodule
`default_nettype wire

### design/rsc_pipe.sv
// Three-stage datapath: input capture, products and conversion, offset sum.
// Depends on rsc_pkg.
`default_nettype none
module rsc_pipe #(
	parameter int unsigned PW = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_v,
	input  wire logic [31:0] src,
	input  wire logic [rsc_pkg::DROW_W-1:0] drow,
	input  wire logic [PW-1:0] col,
	input  wire logic [PW-1:0] plane,
	input  wire logic [PW-1:0] batch,
	input  wire rsc_pkg::cfg_t cfg,
	output logic out_v,
	output logic [rsc_pkg::OFF_W-1:0] offset,
	output logic [31:0] data,
	output logic [rsc_pkg::BYTES_W-1:0] nbytes
);
	localparam int unsigned OW = rsc_pkg::OFF_W;

	logic v_s1, v_s2, v_s3;
	logic [31:0] src_s1;
	logic [rsc_pkg::DROW_W-1:0] drow_s1;
	logic [PW-1:0] col_s1, plane_s1, batch_s1;
	logic [1:0] fmt_s1;
	logic [OW-1:0] pr_s2, pp_s2, pb_s2, pc_s2;
	logic [31:0] data_s2, data_s3;
	logic [rsc_pkg::BYTES_W-1:0] nb_s2, nb_s3;
	logic [OW-1:0] off_s3;
	logic [31:0] conv;
	logic narrow;

	always_comb begin
		case (fmt_s1)
			rsc_pkg::FMT_FP16: conv = {16'd0, rsc_pkg::to_fp16(src_s1)};
			rsc_pkg::FMT_BF16: conv = {16'd0, rsc_pkg::to_bf16(src_s1)};
			default: conv = src_s1;
		endcase
	end
	assign narrow = (fmt_s1 == rsc_pkg::FMT_FP16) || (fmt_s1 == rsc_pkg::FMT_BF16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			src_s1 <= src;
			drow_s1 <= drow;
			col_s1 <= col;
			plane_s1 <= plane;
			batch_s1 <= batch;
			fmt_s1 <= cfg.out_format;
			pr_s2 <= OW'(64'(drow_s1) * 64'(cfg.row_stride));
			pp_s2 <= OW'(64'(plane_s1) * 64'(cfg.plane_stride));
			pb_s2 <= OW'(64'(batch_s1) * 64'(cfg.batch_stride));
			pc_s2 <= narrow ? OW'({col_s1, 1'b0}) : OW'({col_s1, 2'b00});
			data_s2 <= conv;
			nb_s2 <= narrow ? 3'd2 : 3'd4;
			off_s3 <= pr_s2 + pp_s2 + pb_s2 + pc_s2;
			data_s3 <= data_s2;
			nb_s3 <= nb_s2;
		end
	end

	assign out_v = v_s3;
	assign offset = off_s3;
	assign data = data_s3;
	assign nbytes = nb_s3;
endmodule
`default_nettype wire

### design/row_scatter_convert.sv
// Top level of row_scatter_convert: register file, position counters, datapath.
// Depends on rsc_pkg, rsc_position and rsc_pipe.
`default_nettype none
// Accepts one fp32 element per clock while s_tready is high and returns one store
// beat per element through the capture, product and sum registers: byte offset
// dest_row*row_stride + plane*plane_stride + batch*batch_stride + column*size
// and the value as fp32, fp16 or bf16 (round to nearest even). Throughput is one beat
// per cycle; the whole three-stage pipeline holds when the output beat is not taken.
// The user must write registers only while no beats are in flight; not enforced.
module row_scatter_convert #(
	parameter int unsigned MAX_DIM = 65536
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [55:0] s_tdata,  // src_value[31:0], dest_row[55:32]
	input  wire logic [0:0] s_tuser,   // first_element
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [87:0] m_tdata        // store_offset[47:0], store_data[79:48], store_bytes[82:80]
);
	localparam int unsigned PW = $clog2(MAX_DIM);

	rsc_pkg::cfg_t cfg_q;
	logic en, acc;
	logic [PW-1:0] col, plane, batch;
	logic [rsc_pkg::OFF_W-1:0] offset;
	logic [31:0] data;
	logic [rsc_pkg::BYTES_W-1:0] nbytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_length <= 17'd1;
			cfg_q.rows_per_plane <= 17'd1;
			cfg_q.planes_per_batch <= 17'd1;
			cfg_q.row_stride <= '0;
			cfg_q.plane_stride <= '0;
			cfg_q.batch_stride <= '0;
			cfg_q.out_format <= rsc_pkg::FMT_FP32;
		end else if (cfg_we) begin
			case (cfg_index)
				rsc_pkg::REG_ROW_LENGTH:   cfg_q.row_length <= cfg_data[16:0];
				rsc_pkg::REG_ROWS_PLANE:   cfg_q.rows_per_plane <= cfg_data[16:0];
				rsc_pkg::REG_PLANES_BATCH: cfg_q.planes_per_batch <= cfg_data[16:0];
				rsc_pkg::REG_ROW_STRIDE:   cfg_q.row_stride <= cfg_data;
				rsc_pkg::REG_PLANE_STRIDE: cfg_q.plane_stride <= cfg_data;
				rsc_pkg::REG_BATCH_STRIDE: cfg_q.batch_stride <= cfg_data;
				rsc_pkg::REG_OUT_FORMAT:   cfg_q.out_format <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign acc = s_tvalid && en;

	rsc_position #(.PW(PW), .MAX_DIM(MAX_DIM)) u_pos (
		.clk(clk), .arst_n(arst_n), .adv(acc), .first(s_tuser[0]), .cfg(cfg_q),
		.col(col), .plane(plane), .batch(batch)
	);

	rsc_pipe #(.PW(PW)) u_pipe (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(s_tvalid),
		.src(s_tdata[31:0]), .drow(s_tdata[55:32]),
		.col(col), .plane(plane), .batch(batch), .cfg(cfg_q),
		.out_v(m_tvalid), .offset(offset), .data(data), .nbytes(nbytes)
	);

	assign m_tdata = {5'd0, nbytes, data, offset};
endmodule
`default_nettype wire

### tb/row_scatter_convert_test.sv
// Self-checking bench for row_scatter_convert: a scoreboard of expected stores
// against the output stream, with bursty input traffic and random output stalls.
// Depends on rsc_pkg and the row_scatter_convert RTL.
`default_nettype none
module row_scatter_convert_test;
	typedef struct packed {
		logic [47:0] offset;
		logic [31:0] data;
		logic [2:0]  nbytes;
	} store_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [55:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [87:0] m_tdata;

	int errors;
	int stall_mode;
	store_t pending_stores[$];

	logic [16:0] m_row_len, m_rows, m_planes;
	logic [31:0] m_rstride, m_pstride, m_bstride;
	logic [1:0] m_fmt;
	logic [31:0] pos_col, pos_row, pos_plane, pos_batch;

	row_scatter_convert u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [31:0] eff_dim(input logic [16:0] d);
		if (d == 17'd0) return 32'd1;
		if (d > 17'd65536) return 32'd65536;
		return {15'd0, d};
	endfunction

	function automatic logic [15:0] half_of(input logic [31:0] x);
		logic [15:0] sg;
		int e, sh;
		logic [31:0] m, h, rem, hw;
		sg = {x[31], 15'd0};
		if (x[30:23] == 8'hFF) begin
			if (x[22:0] != 23'd0) return sg | 16'h7E00 | {6'd0, x[22:13]};
			return sg | 16'h7C00;
		end
		e = int'(x[30:23]) - 112;
		if (e >= 31) return sg | 16'h7C00;
		if (e <= 0) begin
			if (e < -10) return sg;
			m = {8'd0, 1'b1, x[22:0]};
			sh = 14 - e;
			h = m >> sh;
			rem = m & ((32'd1 << sh) - 32'd1);
			hw = 32'd1 << (sh - 1);
			if (rem > hw || (rem == hw && h[0])) h++;
			return sg | h[15:0];
		end
		h = (32'(e) << 10) | {22'd0, x[22:13]};
		rem = {19'd0, x[12:0]};
		if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h++;
		return sg | h[15:0];
	endfunction

	function automatic logic [15:0] brain_of(input logic [31:0] x);
		logic [31:0] s;
		if (x[30:23] == 8'hFF && x[22:0] != 23'd0) return x[31:16] | 16'h0040;
		s = x + 32'h7FFF + {31'd0, x[16]};
		return s[31:16];
	endfunction

	task automatic predict_store(input logic [31:0] v, input logic [23:0] drow,
			input logic first);
		store_t st;
		logic [63:0] off;
		if (first) begin
			pos_col = 0; pos_row = 0; pos_plane = 0; pos_batch = 0;
		end
		case (m_fmt)
			rsc_pkg::FMT_FP16: begin st.data = {16'd0, half_of(v)}; st.nbytes = 3'd2; end
			rsc_pkg::FMT_BF16: begin st.data = {16'd0, brain_of(v)}; st.nbytes = 3'd2; end
			default: begin st.data = v; st.nbytes = 3'd4; end
		endcase
		off = 64'(drow) * 64'(m_rstride) + 64'(pos_plane) * 64'(m_pstride)
			+ 64'(pos_batch) * 64'(m_bstride) + 64'(pos_col) * 64'(st.nbytes);
		st.offset = off[47:0];
		pending_stores.push_back(st);
		pos_col++;
		if (pos_col >= eff_dim(m_row_len)) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= eff_dim(m_rows)) begin
				pos_row = 0;
				pos_plane++;
				if (pos_plane >= eff_dim(m_planes)) begin
					pos_plane = 0;
					pos_batch++;
					if (pos_batch >= 65536) pos_batch = 0;
				end
			end
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	always @(posedge clk) begin
		store_t st;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_stores.size() == 0) begin
				report("unexpected beat", m_tdata[63:0], 64'd0);
			end else begin
				st = pending_stores.pop_front();
				if (m_tdata[47:0] != st.offset)
					report("offset", 64'(m_tdata[47:0]), 64'(st.offset));
				if (m_tdata[79:48] != st.data)
					report("data", 64'(m_tdata[79:48]), 64'(st.data));
				if (m_tdata[82:80] != st.nbytes)
					report("bytes", 64'(m_tdata[82:80]), 64'(st.nbytes));
			end
		end
	end

	always @(negedge clk) begin
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 2) == 0);
		endcase
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
	end

	task automatic write_reg(input rsc_pkg::reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rsc_pkg::REG_ROW_LENGTH: m_row_len = val[16:0];
			rsc_pkg::REG_ROWS_PLANE: m_rows = val[16:0];
			rsc_pkg::REG_PLANES_BATCH: m_planes = val[16:0];
			rsc_pkg::REG_ROW_STRIDE: m_rstride = val;
			rsc_pkg::REG_PLANE_STRIDE: m_pstride = val;
			rsc_pkg::REG_BATCH_STRIDE: m_bstride = val;
			default: m_fmt = val[1:0];
		endcase
	endtask

	task automatic drain;
		while (pending_stores.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// called at a falling edge; drops tvalid so nothing is in flight during the writes
	task automatic setup(input logic [16:0] rl, input logic [16:0] rp, input logic [16:0] pb,
			input logic [31:0] rs, input logic [31:0] ps, input logic [31:0] bs,
			input logic [1:0] fmt);
		s_tvalid <= 1'b0;
		drain();
		write_reg(rsc_pkg::REG_ROW_LENGTH, 32'(rl));
		write_reg(rsc_pkg::REG_ROWS_PLANE, 32'(rp));
		write_reg(rsc_pkg::REG_PLANES_BATCH, 32'(pb));
		write_reg(rsc_pkg::REG_ROW_STRIDE, rs);
		write_reg(rsc_pkg::REG_PLANE_STRIDE, ps);
		write_reg(rsc_pkg::REG_BATCH_STRIDE, bs);
		write_reg(rsc_pkg::REG_OUT_FORMAT, 32'(fmt));
	endtask

	// drive one beat starting at a falling edge; leaves tvalid high
	task automatic send_element(input logic [31:0] v, input logic [23:0] drow,
			input logic first);
		s_tvalid <= 1'b1;
		s_tdata <= {drow, v};
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_store(v, drow, first);
		@(negedge clk);
	endtask

	task automatic idle_gap;
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 4)) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_float;
		case ($urandom_range(0, 7))
			0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom_range(0, 3))};
			1: return {1'($urandom), 8'($urandom_range(100, 115)), 23'($urandom)};
			2: return {1'($urandom), 8'($urandom_range(140, 146)), 23'($urandom)};
			3: return {1'($urandom), 8'($urandom), 10'($urandom), 13'h1000};
			4: return {1'($urandom), 8'($urandom), 7'($urandom), 16'h8000};
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed;
		logic [31:0] vals[18];
		vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0001, 32'hFFFF_FFFF, 32'h7F80_2000, 32'h0000_0001, 32'h477F_F000,
			32'h4780_0000, 32'h3880_0000, 32'h3300_0000, 32'h3F80_1000, 32'h3F80_3000,
			32'h3F80_8000, 32'h3F81_8000, 32'h7F7F_FFFF, 32'h3380_0001};
		for (int f = 0; f < 4; f++) begin
			setup(17'd2, 17'd2, 17'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'(f));
			for (int i = 0; i < 18; i++)
				send_element(vals[i], (i == 0) ? 24'hFF_FFFF : 24'($urandom), i == 5);
			idle_gap();
		end
		setup(17'd0, 17'd0, 17'd0, 32'd0, 32'd0, 32'd0, rsc_pkg::FMT_FP32);
		for (int i = 0; i < 4; i++) send_element($urandom, 24'($urandom), 1'b0);
		setup(17'h1FFFF, 17'h10000, 17'h1FFFF, 32'd1, 32'd2, 32'd3, rsc_pkg::FMT_BF16);
		for (int i = 0; i < 4; i++) send_element($urandom, 24'($urandom), 1'b0);
		idle_gap();
	endtask

	task automatic test_batch_walk;
		// single-element planes so every beat advances the batch counter
		setup(17'd1, 17'd1, 17'd1, 32'd0, 32'd0, 32'h0001_0001, rsc_pkg::FMT_FP32);
		for (int i = 0; i < 48; i++) send_element($urandom, 24'd0, 1'b0);
		idle_gap();
	endtask

	task automatic test_random;
		int sent, burst, next_setup;
		sent = 0;
		next_setup = 0;
		while (sent < 1200) begin
			if (sent >= next_setup) begin
				setup(17'($urandom_range(0, 6)), 17'($urandom_range(0, 4)),
					17'($urandom_range(0, 3)),
					$urandom, ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 64)),
					$urandom, 2'($urandom_range(0, 3)));
				next_setup = next_setup + 160;
			end
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst; i++) begin
				send_element(rand_float(), 24'($urandom), $urandom_range(0, 40) == 0);
				sent++;
			end
			if ($urandom_range(0, 2) != 0) idle_gap();
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		errors = 0; stall_mode = 0;
		arst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
		m_row_len = 1; m_rows = 1; m_planes = 1;
		m_rstride = 0; m_pstride = 0; m_bstride = 0; m_fmt = rsc_pkg::FMT_FP32;
		pos_col = 0; pos_row = 0; pos_plane = 0; pos_batch = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// reset defaults: every element lands at offset zero
		for (int i = 0; i < 3; i++) send_element($urandom, 24'($urandom), 1'b0);
		idle_gap();
		test_directed();
		test_random();
		test_batch_walk();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
